@@ design/block_scaled_point_quantizer_assert.svh @@
// Assertion macros shared by the quantizer modules.
`ifndef BLOCK_SCALED_POINT_QUANTIZER_ASSERT_SVH
`define BLOCK_SCALED_POINT_QUANTIZER_ASSERT_SVH

// Check that cons holds whenever ante holds, outside reset.
`define BSPQ_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond holds at every edge outside reset.
`define BSPQ_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error(msg);

`endif

@@ design/bspq_pkg.sv @@
package bspq_pkg;

  localparam int COORD_W      = 32;
  localparam int CODE_W       = 8;
  localparam int PIDX_W       = 3;
  localparam int RESULT_SLOTS = 8;

  // One point ready for quantization, with its group context.
  typedef struct packed {
    logic [PIDX_W-1:0]         idx;
    logic                      neg_x;
    logic                      neg_y;
    logic [COORD_W-1:0]        mag_x;
    logic [COORD_W-1:0]        mag_y;
    logic [COORD_W-1:0]        scale_x;
    logic [COORD_W-1:0]        scale_y;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic                      dropped;
    logic                      last;
  } job_t;

endpackage

@@ design/bspq_ifs.sv @@
interface bspq_in_if import bspq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      is_reference;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic                      group_end;

  modport source (output valid, is_reference, pos_x, pos_y, group_end, input ready);
  modport sink   (input valid, is_reference, pos_x, pos_y, group_end, output ready);
endinterface

interface bspq_out_if import bspq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PIDX_W-1:0]         point_index;
  logic signed [CODE_W-1:0]  code_x;
  logic signed [CODE_W-1:0]  code_y;
  logic [COORD_W-1:0]        scale_x;
  logic [COORD_W-1:0]        scale_y;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic                      dropped;
  logic                      last_of_run;

  modport source (output valid, point_index, code_x, code_y, scale_x, scale_y,
                  origin_x, origin_y, dropped, last_of_run, input ready);
  modport sink   (input valid, point_index, code_x, code_y, scale_x, scale_y,
                  origin_x, origin_y, dropped, last_of_run, output ready);
endinterface

@@ design/bspq_front.sv @@
`include "block_scaled_point_quantizer_assert.svh"

module bspq_front import bspq_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  bspq_in_if.sink       in_ch,
  output logic          job_valid,
  output job_t          job,
  input  logic          job_ready
);

  localparam int CAP    = (MAX_POINTS > RESULT_SLOTS) ? RESULT_SLOTS : MAX_POINTS;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;

  typedef enum logic {S_COLLECT, S_WALK} st_t;

  st_t                       st_r;
  logic signed [COORD_W-1:0] ref_x_r, ref_y_r;
  logic [COORD_W-1:0]        max_x_r, max_y_r;
  logic [CNT_W-1:0]          count_r;
  logic                      ovf_r;
  logic [IDX_W-1:0]          k_r;

  logic                      neg_x_r [CAP];
  logic                      neg_y_r [CAP];
  logic [COORD_W-1:0]        mag_x_r [CAP];
  logic [COORD_W-1:0]        mag_y_r [CAP];

  logic                      accept, room, store_pt, push, walk_last;
  logic [COORD_W:0]          dx, dy, ndx, ndy;
  logic [COORD_W-1:0]        ax, ay;
  logic [CNT_W-1:0]          cnt_after;

  assign in_ch.ready = (st_r == S_COLLECT);
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = (count_r < CNT_W'(CAP));
  assign store_pt    = accept && !in_ch.is_reference && room;

  // Offsets in 33 bits so the magnitude always fits 32.
  assign dx  = {in_ch.pos_x[COORD_W-1], in_ch.pos_x} - {ref_x_r[COORD_W-1], ref_x_r};
  assign dy  = {in_ch.pos_y[COORD_W-1], in_ch.pos_y} - {ref_y_r[COORD_W-1], ref_y_r};
  assign ndx = (COORD_W + 1)'(0) - dx;
  assign ndy = (COORD_W + 1)'(0) - dy;
  assign ax  = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
  assign ay  = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];

  always_comb begin
    if (in_ch.is_reference) begin
      cnt_after = '0;
    end else if (room) begin
      cnt_after = count_r + CNT_W'(1);
    end else begin
      cnt_after = count_r;
    end
  end

  assign walk_last = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);
  assign job_valid = (st_r == S_WALK);
  assign push      = job_valid && job_ready;

  always_comb begin
    job.idx      = PIDX_W'(k_r);
    job.neg_x    = neg_x_r[k_r];
    job.neg_y    = neg_y_r[k_r];
    job.mag_x    = mag_x_r[k_r];
    job.mag_y    = mag_y_r[k_r];
    job.scale_x  = max_x_r;
    job.scale_y  = max_y_r;
    job.origin_x = ref_x_r;
    job.origin_y = ref_y_r;
    job.dropped  = ovf_r;
    job.last     = walk_last;
  end

  always_ff @(posedge clk) begin
    if (store_pt) begin
      neg_x_r[count_r[IDX_W-1:0]] <= dx[COORD_W];
      neg_y_r[count_r[IDX_W-1:0]] <= dy[COORD_W];
      mag_x_r[count_r[IDX_W-1:0]] <= ax;
      mag_y_r[count_r[IDX_W-1:0]] <= ay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_COLLECT;
      ref_x_r <= '0;
      ref_y_r <= '0;
      max_x_r <= '0;
      max_y_r <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      k_r     <= '0;
    end else begin
      unique case (st_r)
        S_COLLECT: begin
          if (accept) begin
            if (in_ch.is_reference) begin
              ref_x_r <= in_ch.pos_x;
              ref_y_r <= in_ch.pos_y;
              count_r <= '0;
              max_x_r <= '0;
              max_y_r <= '0;
              ovf_r   <= 1'b0;
            end else if (room) begin
              count_r <= cnt_after;
              if (ax > max_x_r) max_x_r <= ax;
              if (ay > max_y_r) max_y_r <= ay;
            end else begin
              ovf_r <= 1'b1;
            end
            // a reference that closes its own group leaves nothing to emit
            if (in_ch.group_end && cnt_after != '0) begin
              k_r  <= '0;
              st_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (push) begin
            if (walk_last) begin
              count_r <= '0;
              max_x_r <= '0;
              max_y_r <= '0;
              ovf_r   <= 1'b0;
              st_r    <= S_COLLECT;
            end else begin
              k_r <= k_r + IDX_W'(1);
            end
          end
        end
        default: st_r <= S_COLLECT;
      endcase
    end
  end

  `BSPQ_ASSERT_ALWAYS(a_count_cap, clk, rst_n, count_r <= CNT_W'(CAP), "point count over capacity")
  `BSPQ_ASSERT_IMPLY(a_walk_range, clk, rst_n, st_r == S_WALK, CNT_W'(k_r) < count_r, "walk past stored points")
  `BSPQ_ASSERT_IMPLY(a_walk_nonempty, clk, rst_n, job_valid, count_r != '0, "walk on empty group")

endmodule

@@ design/bspq_fifo.sv @@
module bspq_fifo import bspq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  input  job_t wr_data,
  output logic wr_ready,
  output logic rd_valid,
  output job_t rd_data,
  input  logic rd_ready
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  job_t               mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [PTR_W:0]     cnt_r;
  logic               wr, rd;

  assign wr_ready = (cnt_r != (PTR_W + 1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + PTR_W'(1);
      if (rd) rp_r <= rp_r + PTR_W'(1);
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + (PTR_W + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (PTR_W + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ design/bspq_back.sv @@
`include "block_scaled_point_quantizer_assert.svh"

module bspq_back import bspq_pkg::*; #(
  parameter int CODE_LIMIT = 127
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_ready,
  bspq_out_if.source out_ch
);

  localparam int LIM_W  = $clog2(CODE_LIMIT + 1);
  localparam int NUM_W  = COORD_W + LIM_W;
  localparam int CW     = (LIM_W > CODE_W) ? LIM_W : CODE_W;
  localparam int STEP_W = (LIM_W > 1) ? $clog2(LIM_W) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} st_t;

  st_t               st_r;
  job_t              job_r;
  logic [NUM_W-1:0]  rem_x_r, rem_y_r, dsh_x_r, dsh_y_r;
  logic [LIM_W-1:0]  quo_x_r, quo_y_r;
  logic [STEP_W-1:0] step_r;
  logic              zero_x_r, zero_y_r;

  logic                      out_valid_r;
  logic [PIDX_W-1:0]         idx_r;
  logic [CODE_W-1:0]         code_x_r, code_y_r;
  logic [COORD_W-1:0]        scale_x_r, scale_y_r;
  logic signed [COORD_W-1:0] origin_x_r, origin_y_r;
  logic                      dropped_r, last_r;

  logic              ge_x, ge_y, load_out;
  logic [NUM_W-1:0]  sub_x, sub_y;
  logic [LIM_W-1:0]  sat_x, sat_y;
  logic [CW-1:0]     ext_x, ext_y, sgn_x, sgn_y;

  assign job_ready = (st_r == S_IDLE);
  assign load_out  = (st_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // one restoring step per cycle on each axis
  assign ge_x  = (rem_x_r >= dsh_x_r);
  assign ge_y  = (rem_y_r >= dsh_y_r);
  assign sub_x = rem_x_r - dsh_x_r;
  assign sub_y = rem_y_r - dsh_y_r;

  // zero axis maximum forces a zero code; otherwise clamp, then apply sign
  assign sat_x = zero_x_r ? '0 :
                 (quo_x_r > LIM_W'(CODE_LIMIT)) ? LIM_W'(CODE_LIMIT) : quo_x_r;
  assign sat_y = zero_y_r ? '0 :
                 (quo_y_r > LIM_W'(CODE_LIMIT)) ? LIM_W'(CODE_LIMIT) : quo_y_r;
  assign ext_x = CW'(sat_x);
  assign ext_y = CW'(sat_y);
  assign sgn_x = job_r.neg_x ? (CW'(0) - ext_x) : ext_x;
  assign sgn_y = job_r.neg_y ? (CW'(0) - ext_y) : ext_y;

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && job_valid) begin
      job_r    <= job;
      rem_x_r  <= NUM_W'(job.mag_x) * NUM_W'(CODE_LIMIT);
      rem_y_r  <= NUM_W'(job.mag_y) * NUM_W'(CODE_LIMIT);
      dsh_x_r  <= NUM_W'(job.scale_x) << (LIM_W - 1);
      dsh_y_r  <= NUM_W'(job.scale_y) << (LIM_W - 1);
      zero_x_r <= (job.scale_x == '0);
      zero_y_r <= (job.scale_y == '0);
      quo_x_r  <= '0;
      quo_y_r  <= '0;
    end else if (st_r == S_DIV) begin
      if (ge_x) rem_x_r <= sub_x;
      if (ge_y) rem_y_r <= sub_y;
      quo_x_r <= LIM_W'({quo_x_r, ge_x});
      quo_y_r <= LIM_W'({quo_y_r, ge_y});
      dsh_x_r <= dsh_x_r >> 1;
      dsh_y_r <= dsh_y_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !load_out) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            step_r <= STEP_W'(LIM_W - 1);
            st_r   <= S_DIV;
          end
        end
        S_DIV: begin
          if (step_r == '0) begin
            st_r <= S_DONE;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            idx_r       <= job_r.idx;
            code_x_r    <= sgn_x[CODE_W-1:0];
            code_y_r    <= sgn_y[CODE_W-1:0];
            scale_x_r   <= job_r.scale_x;
            scale_y_r   <= job_r.scale_y;
            origin_x_r  <= job_r.origin_x;
            origin_y_r  <= job_r.origin_y;
            dropped_r   <= job_r.dropped;
            last_r      <= job_r.last;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.point_index = idx_r;
  assign out_ch.code_x      = code_x_r;
  assign out_ch.code_y      = code_y_r;
  assign out_ch.scale_x     = scale_x_r;
  assign out_ch.scale_y     = scale_y_r;
  assign out_ch.origin_x    = origin_x_r;
  assign out_ch.origin_y    = origin_y_r;
  assign out_ch.dropped     = dropped_r;
  assign out_ch.last_of_run = last_r;

  `BSPQ_ASSERT_IMPLY(a_quo_x_bound, clk, rst_n, st_r == S_DONE && !zero_x_r, quo_x_r <= LIM_W'(CODE_LIMIT), "X quotient above limit")
  `BSPQ_ASSERT_IMPLY(a_quo_y_bound, clk, rst_n, st_r == S_DONE && !zero_y_r, quo_y_r <= LIM_W'(CODE_LIMIT), "Y quotient above limit")
  `BSPQ_ASSERT_IMPLY(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(st_r == S_DONE), "result shown without finished division")

endmodule

@@ design/block_scaled_point_quantizer.sv @@
// Block-scaled point quantizer.
// in_ch carries 2-D points in signed Q16.16. A transfer with is_reference set
// latches the origin and opens a group; later points are stored, up to
// min(MAX_POINTS, 8), while the largest |offset| per axis is tracked. Points
// beyond capacity are dropped and flagged in the group's results.
// A transfer with group_end set closes the group: out_ch then carries one
// result per stored point, in arrival order, with signed codes
// trunc(CODE_LIMIT * offset / axis_max) and last_of_run on the final one.
// Collection takes one point per cycle while in_ch is ready. Each result
// comes from the shift-subtract divider in the back end, which forms LIM_W
// quotient bits (LIM_W = bits of CODE_LIMIT), one quotient bit per cycle, and
// takes one job at a time. The closing transfer starts the walk; each result
// then passes the job queue, the divider and the result register. in_ch holds
// ready low until a closed group is handed to the two-entry job queue; the
// queue and divider take three points, so larger groups wait on the divider.
// Reset clears origin, maxima, count, queue and output valid; the point store
// needs no clearing. A stall on out_ch holds the result register, then the
// divider, the queue and finally in_ch.
module block_scaled_point_quantizer import bspq_pkg::*; #(
  parameter int MAX_POINTS = 8,
  parameter int CODE_LIMIT = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  bspq_in_if.sink     in_ch,
  bspq_out_if.source  out_ch
);

  // front to queue
  logic job_in_valid, job_in_ready;
  job_t job_in;
  // queue to back
  logic job_out_valid, job_out_ready;
  job_t job_out;

  // collect points, then walk the store into the queue
  bspq_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (job_in_valid),
    .job       (job_in),
    .job_ready (job_in_ready)
  );

  // decouple collection from division
  bspq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (job_in_valid),
    .wr_data  (job_in),
    .wr_ready (job_in_ready),
    .rd_valid (job_out_valid),
    .rd_data  (job_out),
    .rd_ready (job_out_ready)
  );

  // divide, clamp, sign and hold each result until transfer
  bspq_back #(
    .CODE_LIMIT (CODE_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_out_valid),
    .job       (job_out),
    .job_ready (job_out_ready),
    .out_ch    (out_ch)
  );

endmodule

@@ tb/sv/bspq_quant_checker.sv @@
`timescale 1ns / 1ps

module bspq_quant_checker import bspq_pkg::*; #(
  parameter int MAX_POINTS = 8,
  parameter int CODE_LIMIT = 127
) (
  input  logic clk,
  input  logic rst_n,
  bspq_in_if   in_mon,
  bspq_out_if  out_mon,
  output int   fail_count,
  output int   pending_results
);

  localparam int CAPACITY     = (MAX_POINTS > RESULT_SLOTS) ? RESULT_SLOTS : MAX_POINTS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIDX_W-1:0]         idx;
    logic signed [CODE_W-1:0]  code_x;
    logic signed [CODE_W-1:0]  code_y;
    logic [COORD_W-1:0]        scale_x;
    logic [COORD_W-1:0]        scale_y;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic                      dropped;
    logic                      last;
  } point_result_t;

  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] store_x [RESULT_SLOTS];
  logic [COORD_W-1:0] store_y [RESULT_SLOTS];
  int                 stored;
  logic [COORD_W-1:0] peak_x;
  logic [COORD_W-1:0] peak_y;
  logic               overflow;
  point_result_t      expected_codes_q [$];
  int                 failures = 0;

  // |p - r| formed in 33 bits; the magnitude always fits 32 bits.
  function automatic logic [COORD_W:0] offset_mag(logic [COORD_W-1:0] p,
                                                  logic [COORD_W-1:0] r);
    logic signed [COORD_W:0] d;
    d = $signed({p[COORD_W-1], p}) - $signed({r[COORD_W-1], r});
    return d[COORD_W] ? -d : d;
  endfunction

  // trunc(CODE_LIMIT * offset / peak), toward zero, clamped, masked to code width.
  function automatic logic [CODE_W-1:0] scaled_code(logic [COORD_W-1:0] p,
                                                    logic [COORD_W-1:0] r,
                                                    logic [COORD_W-1:0] peak);
    logic signed [COORD_W:0] d;
    logic [63:0]             mag;
    logic [63:0]             q;
    if (peak == '0) return '0;
    d   = $signed({p[COORD_W-1], p}) - $signed({r[COORD_W-1], r});
    mag = {31'b0, offset_mag(p, r)};
    q   = (64'(CODE_LIMIT) * mag) / {32'b0, peak};
    if (q > 64'(CODE_LIMIT)) q = 64'(CODE_LIMIT);
    if (d[COORD_W]) q = -q;
    return q[CODE_W-1:0];
  endfunction

  task automatic accept_point(input logic is_ref, input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py, input logic grp_end);
    logic [COORD_W:0] ax;
    logic [COORD_W:0] ay;
    point_result_t    r;
    if (is_ref) begin
      origin_x = px;
      origin_y = py;
      stored   = 0;
      peak_x   = '0;
      peak_y   = '0;
      overflow = 1'b0;
    end else if (stored < CAPACITY) begin
      ax = offset_mag(px, origin_x);
      ay = offset_mag(py, origin_y);
      store_x[stored] = px;
      store_y[stored] = py;
      stored++;
      if (ax[COORD_W-1:0] > peak_x) peak_x = ax[COORD_W-1:0];
      if (ay[COORD_W-1:0] > peak_y) peak_y = ay[COORD_W-1:0];
    end else begin
      overflow = 1'b1;
    end
    if (!grp_end) return;
    for (int k = 0; k < stored; k++) begin
      r.idx      = PIDX_W'(k);
      r.code_x   = scaled_code(store_x[k], origin_x, peak_x);
      r.code_y   = scaled_code(store_y[k], origin_y, peak_y);
      r.scale_x  = peak_x;
      r.scale_y  = peak_y;
      r.origin_x = origin_x;
      r.origin_y = origin_y;
      r.dropped  = overflow;
      r.last     = (k == stored - 1);
      expected_codes_q.push_back(r);
    end
    stored   = 0;
    peak_x   = '0;
    peak_y   = '0;
    overflow = 1'b0;
  endtask

  task automatic check_result();
    point_result_t got;
    point_result_t want;
    got.idx      = out_mon.point_index;
    got.code_x   = out_mon.code_x;
    got.code_y   = out_mon.code_y;
    got.scale_x  = out_mon.scale_x;
    got.scale_y  = out_mon.scale_y;
    got.origin_x = out_mon.origin_x;
    got.origin_y = out_mon.origin_y;
    got.dropped  = out_mon.dropped;
    got.last     = out_mon.last_of_run;
    if (expected_codes_q.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t: unexpected result idx=%0d cx=%0d cy=%0d", $time,
                 got.idx, got.code_x, got.code_y);
      return;
    end
    want = expected_codes_q.pop_front();
    if (got.idx !== want.idx || got.code_x !== want.code_x ||
        got.code_y !== want.code_y || got.scale_x !== want.scale_x ||
        got.scale_y !== want.scale_y || got.origin_x !== want.origin_x ||
        got.origin_y !== want.origin_y || got.dropped !== want.dropped ||
        got.last !== want.last) begin
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("%0t: mismatch expected idx=%0d cx=%0d cy=%0d sx=%h sy=%h ox=%h oy=%h drop=%b last=%b",
                 $time, want.idx, want.code_x, want.code_y, want.scale_x, want.scale_y,
                 want.origin_x, want.origin_y, want.dropped, want.last);
        $display("%0t:          actual   idx=%0d cx=%0d cy=%0d sx=%h sy=%h ox=%h oy=%h drop=%b last=%b",
                 $time, got.idx, got.code_x, got.code_y, got.scale_x, got.scale_y,
                 got.origin_x, got.origin_y, got.dropped, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      origin_x = '0;
      origin_y = '0;
      stored   = 0;
      peak_x   = '0;
      peak_y   = '0;
      overflow = 1'b0;
      expected_codes_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        accept_point(in_mon.is_reference, in_mon.pos_x, in_mon.pos_y, in_mon.group_end);
    end
    fail_count      <= failures;
    pending_results <= expected_codes_q.size();
  end

endmodule

@@ tb/sv/tb_block_scaled_point_quantizer.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the block-scaled point quantizer. The checker beside
// the block predicts every result from the input transfers and compares; this
// module only drives the channels, paces them and decides pass or fail.
module tb_block_scaled_point_quantizer;
  import bspq_pkg::*;

  localparam int MAX_POINTS   = 8;
  localparam int CODE_LIMIT   = 127;
  localparam int RANDOM_ITEMS = 200;
  // Even with a full group in the divider and the longest random stalls on
  // both sides, no correct run comes near this many cycles without a transfer.
  localparam int STALL_LIMIT  = 2000;
  // Wait this long after the last expected result to catch any stray result.
  localparam int DRAIN_CYCLES = 30;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  int                 tx_idle_pct = 14;
  int                 rx_idle_pct = 45;
  int                 items_sent;
  int                 fail_count;
  int                 pending_results;
  int                 stall_cycles = 0;
  logic [COORD_W-1:0] held_x;
  logic [COORD_W-1:0] held_y;

  bspq_in_if  in_ch ();
  bspq_out_if out_ch ();

  block_scaled_point_quantizer #(
    .MAX_POINTS (MAX_POINTS),
    .CODE_LIMIT (CODE_LIMIT)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bspq_quant_checker #(
    .MAX_POINTS (MAX_POINTS),
    .CODE_LIMIT (CODE_LIMIT)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: drop ready at random in rx_idle_pct of the cycles; change it
  // only at the falling edge so the block samples a settled value.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run once the channels have been silent for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one point and hold it until the transfer. Start and end at a
  // falling edge; valid stays high into the next item unless an idle gap
  // is drawn.
  task automatic send_point(input logic is_ref, input logic [COORD_W-1:0] px,
                            input logic [COORD_W-1:0] py, input logic grp_end);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.is_reference = is_ref;
    in_ch.pos_x        = px;
    in_ch.pos_y        = py;
    in_ch.group_end    = grp_end;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (is_ref) begin
      held_x = px;
      held_y = py;
    end
    items_sent++;
  endtask

  // Origins: mostly anywhere, sometimes at zero or the corners of the Q16.16 range.
  function automatic logic [COORD_W-1:0] pick_origin();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Point coordinate for one axis: anywhere, exactly on the origin (zero
  // peak on that axis), at a range corner, or a random span around origin.
  function automatic logic [COORD_W-1:0] coord_near(logic [COORD_W-1:0] org, int style);
    int span;
    span = $urandom_range(1, 24);
    case (style)
      0:       return $urandom;
      1:       return org;
      2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return org + ($urandom & ((32'd1 << span) - 1)) - (32'd1 << (span - 1));
    endcase
  endfunction

  // Mostly well-formed groups with random content; some groups reuse the
  // held origin, a few overrun the store, and the rest is noise.
  task automatic send_random_group();
    int kind;
    int npts;
    int style_x;
    int style_y;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 4))
        send_point($urandom_range(0, 3) == 0, $urandom, $urandom, $urandom_range(0, 4) == 0);
      return;
    end
    // Open a new group unless continuing on the held origin; now and then
    // close it on the reference itself, which yields no result.
    if (kind >= 20)
      send_point(1'b1, pick_origin(), pick_origin(), $urandom_range(0, 19) == 0);
    npts    = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    style_x = $urandom_range(0, 5);
    style_y = $urandom_range(0, 5);
    for (int i = 0; i < npts; i++)
      send_point(1'b0, coord_near(held_x, style_x), coord_near(held_y, style_y), i == npts - 1);
  endtask

  initial begin
    int directed_items;
    int done;
    in_ch.valid        = 1'b0;
    in_ch.is_reference = 1'b0;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.group_end    = 1'b0;
    items_sent         = 0;
    held_x             = '0;
    held_y             = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Points before any reference use the reset origin of zero.
    send_point(1'b0, 32'h0001_8000, 32'hfffe_0000, 1'b0);
    send_point(1'b0, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    // Reference that also closes the group: empty, no result.
    send_point(1'b1, 32'h0000_1234, 32'h0000_5678, 1'b1);
    // Held origin after emission; X sits on the origin so its peak is zero.
    send_point(1'b0, 32'h0000_1234, 32'h0000_9999, 1'b0);
    send_point(1'b0, 32'h0000_1234, 32'h0000_0078, 1'b1);
    // Widest offsets: full 32-bit magnitude, both signs.
    send_point(1'b1, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(1'b0, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1);
    // Overrun the store; the closing point itself is dropped.
    send_point(1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0);
    for (int i = 0; i < 10; i++)
      send_point(1'b0, i * 32'h0001_0000 + 32'h100, -(i * 32'h0003_0000), i == 9);
    // Single point closing its own group.
    send_point(1'b1, 32'hdead_beef, 32'h1357_9bdf, 1'b0);
    send_point(1'b0, 32'hdeae_0000, 32'h1357_0000, 1'b1);

    // Random part in three pacing phases: sender mostly busy, then receiver
    // mostly busy, then no idling at all.
    directed_items = items_sent;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      done = items_sent - directed_items;
      if (done < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 14;
        rx_idle_pct = 45;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 45;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random_group();
    end
    in_ch.valid = 1'b0;

    // Drain: wait for every predicted result, then hold a while for strays.
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/bspq_pkg.sv
design/bspq_ifs.sv
design/bspq_front.sv
design/bspq_fifo.sv
design/bspq_back.sv
design/block_scaled_point_quantizer.sv
tb/sv/bspq_quant_checker.sv
tb/sv/tb_block_scaled_point_quantizer.sv
